// File: hw/rtl/mm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix multiply package
// Shared widths and the command, write and result structs of the 4x4
// Q16.16 matrix multiplier.
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int ELEM_W  = 32;
  localparam int DEPTH   = 16;
  localparam int ADDR_W  = 4;
  localparam int IDX_W   = 2;
  localparam int PROD_W  = 2 * ELEM_W;
  // Four full products need two guard bits.
  localparam int ACC_W   = PROD_W + 2;
  localparam int TDATA_W = 40;

  typedef struct packed {
    logic                     en;
    logic                     sel;
    logic [ADDR_W-1:0]        addr;
    logic signed [ELEM_W-1:0] data;
  } mm_wr_t;

  typedef struct packed {
    logic              rd_en;
    logic              rd_first;
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
    logic              load;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              last;
  } mm_cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [ELEM_W-1:0] value;
    logic                     sat;
    logic                     last;
  } mm_res_t;

endpackage
`default_nettype wire

// File: hw/rtl/mm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/mm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix multiply datapath
// Operand memories, one shared multiplier, accumulator, scaling with
// saturation, and the result register.
// ----------------------------------------------------------------------------
module mm_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire mm_pkg::mm_wr_t  wr,
  input  wire mm_pkg::mm_cmd_t cmd,
  output logic                 pipe_busy,
  output mm_pkg::mm_res_t      res
);
  import mm_pkg::*;

  logic [ELEM_W-1:0]        rdata_a;
  logic [ELEM_W-1:0]        rdata_b;
  logic                     v1;
  logic                     first1;
  logic                     v2;
  logic                     first2;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  shifted;
  logic                     sat_pos;
  logic                     sat_neg;
  logic signed [ELEM_W-1:0] value_next;

  mm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram_first (
    .clk   (clk),
    .we    (wr.en && !wr.sel),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (cmd.rd_en),
    .raddr (cmd.a_addr),
    .rdata (rdata_a)
  );

  mm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram_second (
    .clk   (clk),
    .we    (wr.en && wr.sel),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (cmd.rd_en),
    .raddr (cmd.b_addr),
    .rdata (rdata_b)
  );

  assign prod_next = $signed(rdata_a) * $signed(rdata_b);
  assign prod_ext  = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
  assign pipe_busy = v1 || v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      first1 <= 1'b0;
      v2     <= 1'b0;
      first2 <= 1'b0;
    end else begin
      v1     <= cmd.rd_en;
      first1 <= cmd.rd_first;
      v2     <= v1;
      first2 <= first1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      prod <= prod_next;
    end
    if (v2) begin
      acc <= first2 ? prod_ext : acc + prod_ext;
    end
  end

  // The floor shift keeps all guard bits; the result fits 32 bits only
  // when bit 31 and every bit above it agree.
  assign shifted = acc >>> FRAC_BITS;
  assign sat_pos = !shifted[ACC_W-1] && (|shifted[ACC_W-2:ELEM_W-1]);
  assign sat_neg = shifted[ACC_W-1] && !(&shifted[ACC_W-2:ELEM_W-1]);

  always_comb begin
    priority if (sat_pos) begin
      value_next = {1'b0, {(ELEM_W-1){1'b1}}};
    end else if (sat_neg) begin
      value_next = {1'b1, {(ELEM_W-1){1'b0}}};
    end else begin
      value_next = shifted[ELEM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res.row   <= cmd.row;
      res.col   <= cmd.col;
      res.value <= value_next;
      res.sat   <= sat_pos || sat_neg;
      res.last  <= cmd.last;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !pipe_busy)
    else $error("result loaded while the accumulation is still running");

  assert property (@(posedge clk) disable iff (rst)
    v2 && !first2 |-> $past(v2, 1))
    else $error("accumulation continued without a preceding term");

  assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |=> v1)
    else $error("issued read did not enter the pipeline");

endmodule
`default_nettype wire

// File: hw/rtl/mm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix multiply controller
// Accepts element loads, then sequences the sixteen dot products and the
// output handshake.
// ----------------------------------------------------------------------------
module mm_ctrl (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_last,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire logic        pipe_busy,
  output mm_pkg::mm_cmd_t  cmd
);
  import mm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [IDX_W-1:0]  k;
  logic [IDX_W-1:0]  k_next;
  logic [ADDR_W-1:0] elem;
  logic [ADDR_W-1:0] elem_next;
  logic [IDX_W-1:0]  row_i;
  logic [IDX_W-1:0]  col_j;

  assign row_i     = elem[ADDR_W-1:IDX_W];
  assign col_j     = elem[IDX_W-1:0];
  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_EMIT);

  always_comb begin
    state_next   = state;
    k_next       = k;
    elem_next    = elem;
    cmd          = '0;
    // Column j of the first matrix against row i of the second.
    cmd.a_addr   = {k, col_j};
    cmd.b_addr   = {row_i, k};
    cmd.rd_first = (k == '0);
    cmd.row      = row_i;
    cmd.col      = col_j;
    cmd.last     = (elem == '1);
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_last) begin
          state_next = ST_ISSUE;
          k_next     = '0;
          elem_next  = '0;
        end
      end
      ST_ISSUE: begin
        cmd.rd_en = 1'b1;
        k_next    = k + 1'b1;
        if (k == '1) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!pipe_busy) begin
          cmd.load   = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          k_next = '0;
          if (elem == '1) begin
            state_next = ST_IDLE;
          end else begin
            elem_next  = elem + 1'b1;
            state_next = ST_ISSUE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
      elem  <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      elem  <= elem_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_EMIT) |-> $past(cmd.load))
    else $error("word presented without a loaded result");

  assert property (@(posedge clk) disable iff (rst)
    pipe_busy |-> !in_ready)
    else $error("input accepted while products are in flight");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) && out_ready && (elem == '1) |=> (state == ST_IDLE))
    else $error("controller did not return to idle after the final word");

endmodule
`default_nettype wire

// File: hw/rtl/matrix4x4_multiply_top.sv
// An element load is written to its operand memory as it is accepted; after
// a word with the multiply flag, the first result is offered once its reads
// are issued, the read, multiply and accumulate pipeline has drained and the
// result register is loaded. Each further element starts after the word before
// it is taken, paced by the single shared multiplier and pipeline draining.
// Reset clears the controller and the pipeline valid flags; matrix elements
// are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// 4x4 matrix multiplier
// Stores two 4x4 Q16.16 matrices one word at a time and streams out their
// saturated product in row-major order.
// ----------------------------------------------------------------------------
module matrix4x4_multiply_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // [1:0] row_index, [3:2] col_index, [35:4] element_value, [39:36] zero
  input  wire logic [mm_pkg::TDATA_W-1:0]  s_tdata,
  // [0] operand_select
  input  wire logic                        s_tuser,
  input  wire logic                        s_tlast,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // [1:0] result_row, [3:2] result_col, [35:4] result_value, [39:36] zero
  output logic      [mm_pkg::TDATA_W-1:0]  m_tdata,
  // [0] saturated
  output logic                             m_tuser,
  output logic                             m_tlast
);
  import mm_pkg::*;

  mm_wr_t  wr;
  mm_cmd_t cmd;
  mm_res_t res;
  logic    pipe_busy;

  // Elements are stored at row * 4 + col.
  assign wr.en   = s_tvalid && s_tready;
  assign wr.sel  = s_tuser;
  assign wr.addr = {s_tdata[1:0], s_tdata[3:2]};
  assign wr.data = s_tdata[35:4];

  mm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_last   (s_tlast),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .pipe_busy (pipe_busy),
    .cmd       (cmd)
  );

  mm_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .cmd       (cmd),
    .pipe_busy (pipe_busy),
    .res       (res)
  );

  assign m_tdata = {{(TDATA_W - ELEM_W - 2 * IDX_W){1'b0}}, res.value, res.col, res.row};
  assign m_tuser = res.sat;
  assign m_tlast = res.last;

endmodule
`default_nettype wire
